// ===== rtl/submatrix_containment_search_defines.svh =====
// Assertion macros for the submatrix containment search block.
// Needs a clock named clk and an active-high reset named rst in the using module.
`ifndef SUBMATRIX_CONTAINMENT_SEARCH_DEFINES_SVH
`define SUBMATRIX_CONTAINMENT_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/scs_pkg.sv =====
// Package for the submatrix containment search block: sizes, codes and microcode.
// Holds the sequencer step, operation and condition types and the control store.
// No dependencies.
`timescale 1ns / 1ps

package scs_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;
  localparam int DIM_W = 7;
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_BIG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BIG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMALL_COLS = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EMPTY,
    S_ISSUE,
    S_COMPARE,
    S_NEXT_ELEM,
    S_NEXT_POS,
    S_HIT,
    S_MISS
  } step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_READ,
    OP_ADV_ELEM,
    OP_ADV_POS,
    OP_PUT_HIT,
    OP_PUT_MISS
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_START,
    COND_TOO_BIG,
    COND_EMPTY,
    COND_MISMATCH,
    COND_LAST_ELEM,
    COND_LAST_POS,
    COND_RSP_FREE
  } cond_t;

  typedef struct packed {
    op_t op;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    unique case (s)
      S_IDLE:      w = '{OP_LOAD,     COND_START,     S_CHECK,    S_IDLE};
      S_CHECK:     w = '{OP_INIT,     COND_TOO_BIG,   S_MISS,     S_EMPTY};
      S_EMPTY:     w = '{OP_NONE,     COND_EMPTY,     S_HIT,      S_ISSUE};
      S_ISSUE:     w = '{OP_READ,     COND_ALWAYS,    S_COMPARE,  S_COMPARE};
      S_COMPARE:   w = '{OP_NONE,     COND_MISMATCH,  S_NEXT_POS, S_NEXT_ELEM};
      S_NEXT_ELEM: w = '{OP_ADV_ELEM, COND_LAST_ELEM, S_HIT,      S_ISSUE};
      S_NEXT_POS:  w = '{OP_ADV_POS,  COND_LAST_POS,  S_MISS,     S_ISSUE};
      S_HIT:       w = '{OP_PUT_HIT,  COND_RSP_FREE,  S_IDLE,     S_HIT};
      S_MISS:      w = '{OP_PUT_MISS, COND_RSP_FREE,  S_IDLE,     S_MISS};
      default:     w = '{OP_NONE,     COND_ALWAYS,    S_IDLE,     S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/submatrix_containment_search.sv =====
// Loads are written while the sequencer stays idle; a search checks the sizes, then posts
// a result after any element compares, each a registered read of both stores, or posts a miss
// when the pattern does not fit. One request is handled at a time; the next is taken the
// cycle after the result is posted, which waits while an earlier result is not yet accepted.
// Reset clears the sequencer, size registers and result valid; stores stay undefined.
// Top level: element stores, size registers, microcoded sequencer; uses scs_pkg.
`timescale 1ns / 1ps
`include "submatrix_containment_search_defines.svh"

module submatrix_containment_search #(
  parameter int MAX_ROWS = scs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = scs_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [scs_pkg::MODE_W-1:0]          mode,
  input  logic [scs_pkg::IDX_W-1:0]           row,
  input  logic [scs_pkg::IDX_W-1:0]           col,
  input  logic signed [scs_pkg::VAL_W-1:0]    value,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                found,
  input  logic                                cfg_we,
  input  logic [scs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [scs_pkg::DIM_W-1:0]           cfg_data
);
  import scs_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [8:0] MaxRows9 = 9'(MAX_ROWS);
  localparam logic [8:0] MaxCols9 = 9'(MAX_COLS);

  logic [DIM_W-1:0] big_rows, big_cols, small_rows, small_cols;
  logic [DIM_W-1:0] br, bc, sr, sc;
  logic [DIM_W-1:0] top, left, r, c;
  logic [VAL_W-1:0] big_mem [DEPTH];
  logic [VAL_W-1:0] pat_mem [DEPTH];
  logic [VAL_W-1:0] big_q, pat_q;
  logic [AW-1:0] wr_addr, big_raddr, pat_raddr;
  logic [7:0] row8, col8, brow8, bcol8, prow8, pcol8;
  step_t step, step_next;
  ucode_t uc;
  logic cond_hit, rsp_free, accept, in_range, big_we, pat_we, rd_en;

  always_comb begin
    br = ({2'b0, big_rows} > MaxRows9) ? MaxRows9[DIM_W-1:0] : big_rows;
    bc = ({2'b0, big_cols} > MaxCols9) ? MaxCols9[DIM_W-1:0] : big_cols;
    sr = ({2'b0, small_rows} > MaxRows9) ? MaxRows9[DIM_W-1:0] : small_rows;
    sc = ({2'b0, small_cols} > MaxCols9) ? MaxCols9[DIM_W-1:0] : small_cols;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      big_rows <= '0;
      big_cols <= '0;
      small_rows <= '0;
      small_cols <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIG_ROWS:   big_rows <= cfg_data;
        REG_BIG_COLS:   big_cols <= cfg_data;
        REG_SMALL_ROWS: small_rows <= cfg_data;
        REG_SMALL_COLS: small_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign uc = ucode_rom(step);
  assign rsp_free = !rsp_valid || rsp_ready;

  always_comb begin
    unique case (uc.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_START:     cond_hit = req_valid && (mode == MODE_SEARCH);
      COND_TOO_BIG:   cond_hit = (bc < sc) || (br < sr);
      COND_EMPTY:     cond_hit = (sr == '0) || (sc == '0);
      COND_MISMATCH:  cond_hit = (big_q != pat_q);
      COND_LAST_ELEM: cond_hit = (r == sr - 7'd1) && (c == sc - 7'd1);
      COND_LAST_POS:  cond_hit = (top == br - sr) && (left == bc - sc);
      COND_RSP_FREE:  cond_hit = rsp_free;
      default:        cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    step_next = cond_hit ? uc.tgt_true : uc.tgt_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    req_ready = (uc.op == OP_LOAD);
    rd_en = (uc.op == OP_READ);
    accept = req_valid && req_ready;
    in_range = ({3'b0, row} < MaxRows9) && ({3'b0, col} < MaxCols9);
    big_we = accept && in_range && (mode == MODE_BIG);
    pat_we = accept && in_range && (mode == MODE_PATTERN);
  end

  always_comb begin
    row8 = {2'b0, row};
    col8 = {2'b0, col};
    brow8 = {1'b0, top} + {1'b0, r};
    bcol8 = {1'b0, left} + {1'b0, c};
    prow8 = {1'b0, r};
    pcol8 = {1'b0, c};
    wr_addr = {row8[RW-1:0], col8[CW-1:0]};
    big_raddr = {brow8[RW-1:0], bcol8[CW-1:0]};
    pat_raddr = {prow8[RW-1:0], pcol8[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (big_we) begin
      big_mem[wr_addr] <= value;
    end
    if (rd_en) begin
      big_q <= big_mem[big_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[wr_addr] <= value;
    end
    if (rd_en) begin
      pat_q <= pat_mem[pat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (uc.op)
      OP_INIT: begin
        top <= '0;
        left <= '0;
        r <= '0;
        c <= '0;
      end
      OP_ADV_ELEM: begin
        if (c == sc - 7'd1) begin
          c <= '0;
          r <= r + 7'd1;
        end else begin
          c <= c + 7'd1;
        end
      end
      OP_ADV_POS: begin
        r <= '0;
        c <= '0;
        if (left == bc - sc) begin
          left <= '0;
          top <= top + 7'd1;
        end else begin
          left <= left + 7'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free && (uc.op == OP_PUT_HIT || uc.op == OP_PUT_MISS)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_free && (uc.op == OP_PUT_HIT || uc.op == OP_PUT_MISS)) begin
      found <= (uc.op == OP_PUT_HIT);
    end
  end

  `SCS_ASSERT_NOW(a_compare_after_read, step == S_COMPARE, $past(step) == S_ISSUE, "compare without a read in the step before")
  `SCS_ASSERT_NOW(a_read_in_bounds, step == S_ISSUE, (r < sr) && (c < sc) && (top <= br - sr) && (left <= bc - sc), "store read outside the placement")
  `SCS_ASSERT_NEXT(a_search_start, step == S_IDLE && req_valid && mode == MODE_SEARCH, step == S_CHECK, "search request did not start the sequence")
  `SCS_ASSERT_NOW(a_busy_no_request, step != S_IDLE, !req_ready, "request taken while a search runs")

endmodule

// ===== verif/submatrix_containment_search_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for submatrix_containment_search: directed and random requests.
// Predicts the found flag from its own copy of both element stores and the size registers.
// Depends on scs_pkg and the submatrix_containment_search RTL.

module submatrix_containment_search_tb;
  import scs_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned MAX_R = MAX_ROWS_DEF;
  localparam int unsigned MAX_C = MAX_COLS_DEF;

  class containment_scoreboard;
    bit [VAL_W-1:0] big_mem [MAX_R*MAX_C];
    bit [VAL_W-1:0] pat_mem [MAX_R*MAX_C];
    bit big_written [MAX_R*MAX_C];
    bit pat_written [MAX_R*MAX_C];
    bit [DIM_W-1:0] big_rows, big_cols, small_rows, small_cols;
    bit expected_found [$];
    int unsigned mismatches;

    function int unsigned clamp_size(bit [DIM_W-1:0] v, int unsigned lim);
      return (v > lim) ? lim : v;
    endfunction

    function void set_size(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        REG_BIG_ROWS: big_rows = data;
        REG_BIG_COLS: big_cols = data;
        REG_SMALL_ROWS: small_rows = data;
        REG_SMALL_COLS: small_cols = data;
        default: ;
      endcase
    endfunction

    function bit pattern_present();
      int unsigned br, bc, sr, sc;
      bit hit;
      br = clamp_size(big_rows, MAX_R);
      bc = clamp_size(big_cols, MAX_C);
      sr = clamp_size(small_rows, MAX_R);
      sc = clamp_size(small_cols, MAX_C);
      if (bc < sc || br < sr) return 1'b0;
      for (int unsigned top = 0; top <= br - sr; top++) begin
        for (int unsigned left = 0; left <= bc - sc; left++) begin
          hit = 1'b1;
          for (int unsigned r = 0; r < sr && hit; r++) begin
            for (int unsigned c = 0; c < sc && hit; c++) begin
              if (big_mem[(top + r) * MAX_C + left + c] != pat_mem[r * MAX_C + c]) hit = 1'b0;
            end
          end
          if (hit) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [MODE_W-1:0] m, logic [IDX_W-1:0] r,
                               logic [IDX_W-1:0] c, logic [VAL_W-1:0] v);
      int unsigned idx;
      idx = r * MAX_C + c;
      case (m)
        MODE_BIG: begin
          big_mem[idx] = v;
          big_written[idx] = 1'b1;
        end
        MODE_PATTERN: begin
          pat_mem[idx] = v;
          pat_written[idx] = 1'b1;
        end
        MODE_SEARCH: expected_found.push_back(pattern_present());
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("%0t ns: mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_found(logic got);
      bit want;
      if (expected_found.size() == 0) begin
        report_mismatch($sformatf("found=%b with no search outstanding", got));
        return;
      end
      want = expected_found.pop_front();
      if (got !== want) report_mismatch($sformatf("found=%b, predicted %b", got, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [MODE_W-1:0] mode = '0;
  logic [IDX_W-1:0] row = '0;
  logic [IDX_W-1:0] col = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic found;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  containment_scoreboard sb = new();
  bit no_idle = 1'b0;
  int unsigned value_span = 4;
  int unsigned requests_sent = 0;
  int unsigned searches_sent = 0;

  submatrix_containment_search dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .mode(mode),
    .row(row),
    .col(col),
    .value(value),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .found(found),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // All driving tasks start and end just after a falling edge.
  task automatic send_request(input logic [MODE_W-1:0] m, input int unsigned r,
                              input int unsigned c, input logic [VAL_W-1:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = m;
    row = IDX_W'(r);
    col = IDX_W'(c);
    value = v;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(mode, row, col, value);
    if (m != MODE_UNUSED) requests_sent++;
    if (m == MODE_SEARCH) searches_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid = 1'b0;
    while (sb.expected_found.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    wait_drained();
    cfg_index = idx;
    cfg_data = data;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_size(idx, data);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    return ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, value_span - 1);
  endfunction

  function automatic int unsigned pick_index(int unsigned lim);
    return (lim == 0) ? $urandom_range(0, 63) : $urandom_range(0, lim - 1);
  endfunction

  // A search only ever reads elements that have been written beforehand.
  task automatic run_search();
    int unsigned br, bc, sr, sc;
    br = sb.clamp_size(sb.big_rows, MAX_R);
    bc = sb.clamp_size(sb.big_cols, MAX_C);
    sr = sb.clamp_size(sb.small_rows, MAX_R);
    sc = sb.clamp_size(sb.small_cols, MAX_C);
    for (int unsigned r = 0; r < br; r++)
      for (int unsigned c = 0; c < bc; c++)
        if (!sb.big_written[r * MAX_C + c]) send_request(MODE_BIG, r, c, pick_value());
    for (int unsigned r = 0; r < sr; r++)
      for (int unsigned c = 0; c < sc; c++)
        if (!sb.pat_written[r * MAX_C + c]) send_request(MODE_PATTERN, r, c, pick_value());
    send_request(MODE_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
  endtask

  task automatic plant_pattern(input int unsigned br, input int unsigned bc,
                               input int unsigned sr, input int unsigned sc);
    int unsigned top, left;
    if (sr == 0 || sc == 0 || sr > br || sc > bc) return;
    top = $urandom_range(0, br - sr);
    left = $urandom_range(0, bc - sc);
    for (int unsigned r = 0; r < sr; r++)
      for (int unsigned c = 0; c < sc; c++)
        send_request(MODE_BIG, top + r, left + c, sb.pat_mem[r * MAX_C + c]);
    run_search();
  endtask

  initial begin : result_sink
    int unsigned stall;
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      sb.check_found(found);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned kind, br, bc, sr, sc;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(MODE_UNUSED, 63, 63, 32'h8000_0000);
    send_request(MODE_UNUSED, 0, 0, 32'h7fff_ffff);
    run_search();
    write_size(REG_BIG_ROWS, 7'd3);
    write_size(REG_BIG_COLS, 7'd3);
    write_size(REG_SMALL_COLS, 7'd5);
    run_search();
    write_size(REG_SMALL_COLS, 7'd2);
    run_search();
    write_size(REG_SMALL_ROWS, 7'd2);
    write_size(REG_SMALL_COLS, 7'd0);
    run_search();
    write_size(REG_SMALL_COLS, 7'd2);
    send_request(MODE_BIG, 0, 0, 32'h7fff_ffff);
    send_request(MODE_BIG, 0, 1, 32'h0);
    send_request(MODE_BIG, 1, 0, 32'h0);
    send_request(MODE_BIG, 1, 1, 32'h8000_0000);
    send_request(MODE_PATTERN, 0, 0, 32'h7fff_ffff);
    send_request(MODE_PATTERN, 0, 1, 32'h0);
    send_request(MODE_PATTERN, 1, 0, 32'h0);
    send_request(MODE_PATTERN, 1, 1, 32'h8000_0000);
    run_search();
    send_request(MODE_PATTERN, 1, 1, 32'h8000_0001);
    run_search();
    write_size(REG_SMALL_ROWS, 7'd4);
    run_search();
    write_size(REG_BIG_ROWS, 7'd127);
    write_size(REG_BIG_COLS, 7'd1);
    write_size(REG_SMALL_ROWS, 7'd1);
    write_size(REG_SMALL_COLS, 7'd1);
    send_request(MODE_BIG, 63, 0, 32'h5a5a_a5a5);
    send_request(MODE_PATTERN, 0, 0, 32'h5a5a_a5a5);
    run_search();
    write_size(REG_SMALL_ROWS, 7'd65);
    run_search();
    write_size(REG_BIG_ROWS, 7'd1);
    write_size(REG_BIG_COLS, 7'd127);
    write_size(REG_SMALL_ROWS, 7'd1);
    write_size(REG_SMALL_COLS, 7'd65);
    run_search();
    write_size(REG_BIG_ROWS, 7'd10);
    write_size(REG_SMALL_ROWS, 7'd64);
    run_search();

    while (requests_sent < 450 || searches_sent < 60) begin
      write_size(REG_BIG_ROWS, DIM_W'($urandom_range(0, 8)));
      write_size(REG_BIG_COLS, DIM_W'($urandom_range(0, 8)));
      write_size(REG_SMALL_ROWS, DIM_W'($urandom_range(0, 3)));
      write_size(REG_SMALL_COLS, DIM_W'($urandom_range(0, 3)));
      no_idle = ($urandom_range(0, 4) == 0);
      value_span = $urandom_range(2, 4);
      br = sb.clamp_size(sb.big_rows, MAX_R);
      bc = sb.clamp_size(sb.big_cols, MAX_C);
      sr = sb.clamp_size(sb.small_rows, MAX_R);
      sc = sb.clamp_size(sb.small_cols, MAX_C);
      repeat ($urandom_range(10, 30)) begin
        kind = $urandom_range(0, 99);
        if (kind < 38) begin
          send_request(MODE_BIG, pick_index(br), pick_index(bc), pick_value());
        end else if (kind < 52) begin
          send_request(MODE_PATTERN, pick_index(sr), pick_index(sc), pick_value());
        end else if (kind < 60) begin
          send_request($urandom_range(0, 1) ? MODE_PATTERN : MODE_BIG,
                       $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
        end else if (kind < 64) begin
          send_request(MODE_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
        end else if (kind < 74) begin
          plant_pattern(br, bc, sr, sc);
        end else if (kind < 97) begin
          run_search();
        end else begin
          wait_drained();
        end
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_found.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/scs_pkg.sv
rtl/submatrix_containment_search.sv
verif/submatrix_containment_search_tb.sv
